// File: rtl/d_ary_priority_heap_assert.svh
// Assertion macros for the d-ary heap RTL.
`ifndef D_ARY_PRIORITY_HEAP_ASSERT_SVH
`define D_ARY_PRIORITY_HEAP_ASSERT_SVH
`ifndef ASSERT_OFF
`define DAH_ASSERT(lbl, c, r, cond) \
    lbl: assert property (@(posedge c) disable iff (!r) (cond)) \
        else $error("assertion failed");
`define DAH_ASSERT_IMP(lbl, c, r, ante, cons) \
    lbl: assert property (@(posedge c) disable iff (!r) (ante) |-> (cons)) \
        else $error("assertion failed");
`define DAH_ASSERT_NXT(lbl, c, r, ante, cons) \
    lbl: assert property (@(posedge c) disable iff (!r) (ante) |=> (cons)) \
        else $error("assertion failed");
`else
`define DAH_ASSERT(lbl, c, r, cond)
`define DAH_ASSERT_IMP(lbl, c, r, ante, cons)
`define DAH_ASSERT_NXT(lbl, c, r, ante, cons)
`endif
`endif

// File: rtl/dah_pkg.sv
`timescale 1ns / 1ps
package dah_pkg;

    localparam int CAPACITY  = 1024;
    localparam int MAX_ARITY = 8;
    localparam int ADDR_W    = $clog2(CAPACITY);
    localparam int CNT_W     = $clog2(CAPACITY + 1);
    localparam int KEY_W     = 32;
    localparam int ARY_W     = 4;
    localparam int CFG_IDX_W = 2;
    localparam int DIV_K     = ADDR_W + 4;
    localparam int FIRST_W   = ADDR_W + ARY_W + 1;

    localparam logic [CFG_IDX_W-1:0] REG_ARITY     = CFG_IDX_W'(0);
    localparam logic [CFG_IDX_W-1:0] REG_START_MIN = CFG_IDX_W'(1);

    typedef enum logic [1:0] {
        K_INSERT  = 2'd0,
        K_EXTRACT = 2'd1,
        K_FLIP    = 2'd2,
        K_NONE    = 2'd3
    } kind_t;

    typedef enum logic [1:0] {
        ST_OK    = 2'd0,
        ST_EMPTY = 2'd1,
        ST_FULL  = 2'd2
    } status_t;

    typedef enum logic [3:0] {
        S_IDLE,
        S_UP_DIV,
        S_UP_RD,
        S_UP_CMP,
        S_EX_LAST,
        S_EX_LD,
        S_FL_NEXT,
        S_FL_LD,
        S_SD_MUL,
        S_SD_CHK,
        S_SD_SCAN,
        S_SD_DEC,
        S_RESP
    } state_t;

    typedef struct packed {
        status_t                  status;
        logic signed [KEY_W-1:0]  top_key;
        logic [CNT_W-1:0]         count;
        logic                     order_is_min;
    } res_t;

    typedef struct packed {
        logic load;
        logic value;
    } min_load_t;

    function automatic logic beats(logic signed [KEY_W-1:0] a,
                                   logic signed [KEY_W-1:0] b,
                                   logic is_min);
        beats = is_min ? (a < b) : (a > b);
    endfunction

    function automatic logic [ARY_W-1:0] eff_arity(logic [ARY_W-1:0] a);
        logic [ARY_W-1:0] d;
        d = a;
        if (a < ARY_W'(2))
            d = ARY_W'(2);
        else if (int'(a) > MAX_ARITY)
            d = ARY_W'(MAX_ARITY);
        eff_arity = d;
    endfunction

    // ceil(2^DIV_K / d); exact quotient for x < CAPACITY after >> DIV_K
    function automatic logic [DIV_K-1:0] recip(logic [ARY_W-1:0] d);
        logic [DIV_K-1:0] r;
        case (d)
            4'd3:    r = DIV_K'(((1 << DIV_K) + 2) / 3);
            4'd4:    r = DIV_K'((1 << DIV_K) / 4);
            4'd5:    r = DIV_K'(((1 << DIV_K) + 4) / 5);
            4'd6:    r = DIV_K'(((1 << DIV_K) + 5) / 6);
            4'd7:    r = DIV_K'(((1 << DIV_K) + 6) / 7);
            4'd8:    r = DIV_K'((1 << DIV_K) / 8);
            4'd9:    r = DIV_K'(((1 << DIV_K) + 8) / 9);
            4'd10:   r = DIV_K'(((1 << DIV_K) + 9) / 10);
            4'd11:   r = DIV_K'(((1 << DIV_K) + 10) / 11);
            4'd12:   r = DIV_K'(((1 << DIV_K) + 11) / 12);
            4'd13:   r = DIV_K'(((1 << DIV_K) + 12) / 13);
            4'd14:   r = DIV_K'(((1 << DIV_K) + 13) / 14);
            4'd15:   r = DIV_K'(((1 << DIV_K) + 14) / 15);
            default: r = DIV_K'((1 << DIV_K) / 2);
        endcase
        recip = r;
    endfunction

endpackage

// File: rtl/dah_ram.sv
`timescale 1ns / 1ps
module dah_ram #(
    parameter int DEPTH = 1024,
    parameter int WIDTH = 32
) (
    input  logic                     clk,
    input  logic                     we,
    input  logic [$clog2(DEPTH)-1:0] waddr,
    input  logic [WIDTH-1:0]         wdata,
    input  logic [$clog2(DEPTH)-1:0] raddr,
    output logic [WIDTH-1:0]         rdata
);

    logic [WIDTH-1:0] mem [DEPTH];

    always_ff @(posedge clk)
    begin
        if (we)
            mem[waddr] <= wdata;
    end

    always_ff @(posedge clk)
    begin
        rdata <= mem[raddr];
    end

endmodule

// File: rtl/dah_ctrl.sv
`timescale 1ns / 1ps
`include "d_ary_priority_heap_assert.svh"
module dah_ctrl (
    input  logic                         clk,
    input  logic                         rst_n,
    input  logic                         in_valid,
    output logic                         in_ready,
    input  dah_pkg::kind_t               kind,
    input  logic signed [31:0]           key_in,
    input  logic [dah_pkg::ARY_W-1:0]    ary,
    input  dah_pkg::min_load_t           min_load,
    output logic                         res_valid,
    input  logic                         res_ready,
    output dah_pkg::res_t                res,
    output logic                         ram_we,
    output logic [dah_pkg::ADDR_W-1:0]   ram_waddr,
    output logic [dah_pkg::KEY_W-1:0]    ram_wdata,
    output logic [dah_pkg::ADDR_W-1:0]   ram_raddr,
    input  logic [dah_pkg::KEY_W-1:0]    ram_rdata
);
    import dah_pkg::*;

    state_t                   state_reg, state_next;
    logic [CNT_W-1:0]         cnt_reg, cnt_next;
    logic                     min_reg, min_next;
    kind_t                    op_reg, op_next;
    status_t                  status_reg, status_next;
    logic signed [KEY_W-1:0]  top_reg, top_next;
    logic [ADDR_W-1:0]        pos_reg, pos_next;
    logic [ADDR_W-1:0]        par_reg, par_next;
    logic signed [KEY_W-1:0]  cur_reg, cur_next;
    logic signed [KEY_W-1:0]  best_key_reg, best_key_next;
    logic [ADDR_W-1:0]        best_idx_reg, best_idx_next;
    logic [FIRST_W-1:0]       first_reg, first_next;
    logic [ARY_W:0]           k_reg, k_next;
    logic [ADDR_W-1:0]        ridx_reg, ridx_next;
    logic [ADDR_W-1:0]        i_reg, i_next;

    logic signed [KEY_W-1:0]  rd_key;
    logic [ADDR_W+DIV_K-1:0]  prod;
    logic [FIRST_W-1:0]       child_idx;
    logic                     take;

    assign rd_key    = ram_rdata;
    // parent = (pos - 1) / arity via reciprocal multiply
    assign prod      = (ADDR_W+DIV_K)'(pos_reg - ADDR_W'(1))
                     * (ADDR_W+DIV_K)'(recip(ary));
    assign child_idx = first_reg + FIRST_W'(k_reg);
    assign take      = (k_reg == (ARY_W+1)'(1)) || beats(rd_key, best_key_reg, min_reg);

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= S_IDLE;
            cnt_reg   <= '0;
            min_reg   <= 1'b1;
        end
        else
        begin
            state_reg <= state_next;
            cnt_reg   <= cnt_next;
            min_reg   <= min_next;
        end
    end

    always_ff @(posedge clk)
    begin
        op_reg       <= op_next;
        status_reg   <= status_next;
        top_reg      <= top_next;
        pos_reg      <= pos_next;
        par_reg      <= par_next;
        cur_reg      <= cur_next;
        best_key_reg <= best_key_next;
        best_idx_reg <= best_idx_next;
        first_reg    <= first_next;
        k_reg        <= k_next;
        ridx_reg     <= ridx_next;
        i_reg        <= i_next;
    end

    always_comb
    begin
        state_next    = state_reg;
        cnt_next      = cnt_reg;
        min_next      = min_reg;
        op_next       = op_reg;
        status_next   = status_reg;
        top_next      = top_reg;
        pos_next      = pos_reg;
        par_next      = par_reg;
        cur_next      = cur_reg;
        best_key_next = best_key_reg;
        best_idx_next = best_idx_reg;
        first_next    = first_reg;
        k_next        = k_reg;
        ridx_next     = ridx_reg;
        i_next        = i_reg;
        in_ready      = 1'b0;
        res_valid     = 1'b0;
        ram_we        = 1'b0;
        ram_waddr     = pos_reg;
        ram_wdata     = cur_reg;
        ram_raddr     = '0;

        unique case (state_reg)
            S_IDLE:
            begin
                in_ready = 1'b1;
                if (min_load.load && cnt_reg == '0)
                    min_next = min_load.value;
                if (in_valid)
                begin
                    op_next     = kind;
                    status_next = ST_OK;
                    top_next    = '0;
                    state_next  = S_RESP;
                    case (kind)
                        K_INSERT:
                        begin
                            if (cnt_reg == CNT_W'(CAPACITY))
                                status_next = ST_FULL;
                            else
                            begin
                                pos_next   = cnt_reg[ADDR_W-1:0];
                                cur_next   = key_in;
                                cnt_next   = cnt_reg + CNT_W'(1);
                                state_next = S_UP_DIV;
                            end
                        end
                        K_EXTRACT:
                        begin
                            if (cnt_reg == '0)
                                status_next = ST_EMPTY;
                            else
                            begin
                                ram_raddr  = '0;
                                cnt_next   = cnt_reg - CNT_W'(1);
                                state_next = S_EX_LAST;
                            end
                        end
                        K_FLIP:
                        begin
                            min_next   = !min_reg;
                            i_next     = cnt_reg[CNT_W-1:1];
                            state_next = S_FL_NEXT;
                        end
                        default:
                        begin
                        end
                    endcase
                end
            end
            S_UP_DIV:
            begin
                if (pos_reg == '0)
                begin
                    ram_we     = 1'b1;
                    state_next = S_RESP;
                end
                else
                begin
                    par_next   = prod[ADDR_W+DIV_K-1:DIV_K];
                    state_next = S_UP_RD;
                end
            end
            S_UP_RD:
            begin
                ram_raddr  = par_reg;
                state_next = S_UP_CMP;
            end
            S_UP_CMP:
            begin
                ram_we = 1'b1;
                if (beats(cur_reg, rd_key, min_reg))
                begin
                    ram_wdata  = rd_key;
                    pos_next   = par_reg;
                    state_next = S_UP_DIV;
                end
                else
                    state_next = S_RESP;
            end
            S_EX_LAST:
            begin
                top_next   = rd_key;
                ram_raddr  = cnt_reg[ADDR_W-1:0];
                state_next = S_EX_LD;
            end
            S_EX_LD:
            begin
                cur_next   = rd_key;
                pos_next   = '0;
                state_next = S_SD_MUL;
            end
            S_FL_NEXT:
            begin
                if (i_reg == '0)
                    state_next = S_RESP;
                else
                begin
                    ram_raddr  = i_reg - ADDR_W'(1);
                    pos_next   = i_reg - ADDR_W'(1);
                    i_next     = i_reg - ADDR_W'(1);
                    state_next = S_FL_LD;
                end
            end
            S_FL_LD:
            begin
                cur_next   = rd_key;
                state_next = S_SD_MUL;
            end
            S_SD_MUL:
            begin
                first_next = FIRST_W'(ary) * FIRST_W'(pos_reg) + FIRST_W'(1);
                state_next = S_SD_CHK;
            end
            S_SD_CHK:
            begin
                if (first_reg >= FIRST_W'(cnt_reg))
                begin
                    // leaf: the hole takes the sifted key
                    ram_we     = 1'b1;
                    state_next = (op_reg == K_FLIP) ? S_FL_NEXT : S_RESP;
                end
                else
                begin
                    ram_raddr  = first_reg[ADDR_W-1:0];
                    ridx_next  = first_reg[ADDR_W-1:0];
                    k_next     = (ARY_W+1)'(1);
                    state_next = S_SD_SCAN;
                end
            end
            S_SD_SCAN:
            begin
                // one child arrives per cycle; the next read goes out in parallel
                if (take)
                begin
                    best_key_next = rd_key;
                    best_idx_next = ridx_reg;
                end
                if (k_reg < {1'b0, ary} && child_idx < FIRST_W'(cnt_reg))
                begin
                    ram_raddr = child_idx[ADDR_W-1:0];
                    ridx_next = child_idx[ADDR_W-1:0];
                    k_next    = k_reg + (ARY_W+1)'(1);
                end
                else
                    state_next = S_SD_DEC;
            end
            S_SD_DEC:
            begin
                ram_we = 1'b1;
                if (beats(best_key_reg, cur_reg, min_reg))
                begin
                    ram_wdata  = best_key_reg;
                    pos_next   = best_idx_reg;
                    state_next = S_SD_MUL;
                end
                else
                    state_next = (op_reg == K_FLIP) ? S_FL_NEXT : S_RESP;
            end
            S_RESP:
            begin
                res_valid = 1'b1;
                if (res_ready)
                    state_next = S_IDLE;
            end
            default:
                state_next = S_IDLE;
        endcase
    end

    assign res = '{status: status_reg, top_key: top_reg, count: cnt_reg,
                   order_is_min: min_reg};

    `DAH_ASSERT(a_cnt_cap, clk, rst_n, cnt_reg <= CNT_W'(CAPACITY))
    `DAH_ASSERT_IMP(a_scan_in_range, clk, rst_n, state_reg == S_SD_SCAN,
        CNT_W'(ridx_reg) < cnt_reg)
    `DAH_ASSERT_IMP(a_empty_count, clk, rst_n, res_valid && status_reg == ST_EMPTY,
        cnt_reg == '0)
    `DAH_ASSERT_NXT(a_accept_busy, clk, rst_n, in_valid && in_ready,
        state_reg != S_IDLE)

endmodule

// File: rtl/d_ary_priority_heap.sv
`timescale 1ns / 1ps
// d-ary priority heap over signed 32-bit keys, up to 1024 entries.
// Input channel (in_valid/in_ready, kind, key_in): one request per operation,
// insert, extract top or flip min/max order. Output channel
// (out_valid/out_ready): exactly one result per request, in order.
// Config port (cfg_we, cfg_index, cfg_data): index 0 arity (2..8, clamped),
// index 1 start_as_min; a write sets the current order, and only while idle and empty.
// Timing: one request is processed at a time out of a single-port-read
// store. Insert climbs level by level toward the root; extract descends
// level by level, reading each node's children one after another. Flip
// runs one sift-down on each of the first count/2 nodes, last first, and
// so scales with the entry count. Dropped, empty and no-op requests go
// straight to the result.
// The result sits in an output register; a new request is taken while it
// waits. A stalled receiver holds the result and, once the next operation
// completes, holds the block too.
// Reset: empty heap, arity 2, min order. The store is not cleared.
module d_ary_priority_heap (
    input  logic                            clk,
    input  logic                            rst_n,
    input  logic                            in_valid,
    output logic                            in_ready,
    input  logic [1:0]                      kind,
    input  logic signed [31:0]              key_in,
    output logic                            out_valid,
    input  logic                            out_ready,
    output logic [1:0]                      status,
    output logic signed [31:0]              top_key,
    output logic [10:0]                     entry_count,
    output logic                            order_is_min,
    input  logic                            cfg_we,
    input  logic [dah_pkg::CFG_IDX_W-1:0]   cfg_index,
    input  logic [3:0]                      cfg_data
);
    import dah_pkg::*;

    logic [ARY_W-1:0]      arity_reg;
    logic                  out_valid_reg;
    res_t                  out_reg;
    res_t                  res;
    logic                  res_valid;
    logic                  res_ready;
    min_load_t             min_load;
    logic                  ram_we;
    logic [ADDR_W-1:0]     ram_waddr;
    logic [KEY_W-1:0]      ram_wdata;
    logic [ADDR_W-1:0]     ram_raddr;
    logic [KEY_W-1:0]      ram_rdata;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            arity_reg <= ARY_W'(2);
        else if (cfg_we && cfg_index == REG_ARITY)
            arity_reg <= cfg_data;
    end

    assign min_load = '{load: cfg_we && cfg_index == REG_START_MIN, value: cfg_data[0]};

    assign res_ready = !out_valid_reg || out_ready;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            out_valid_reg <= 1'b0;
        else if (res_ready)
            out_valid_reg <= res_valid;
    end

    always_ff @(posedge clk)
    begin
        if (res_valid && res_ready)
            out_reg <= res;
    end

    dah_ctrl u_ctrl (
        .clk       (clk),
        .rst_n     (rst_n),
        .in_valid  (in_valid),
        .in_ready  (in_ready),
        .kind      (kind_t'(kind)),
        .key_in    (key_in),
        .ary       (eff_arity(arity_reg)),
        .min_load  (min_load),
        .res_valid (res_valid),
        .res_ready (res_ready),
        .res       (res),
        .ram_we    (ram_we),
        .ram_waddr (ram_waddr),
        .ram_wdata (ram_wdata),
        .ram_raddr (ram_raddr),
        .ram_rdata (ram_rdata)
    );

    dah_ram #(
        .DEPTH (CAPACITY),
        .WIDTH (KEY_W)
    ) u_ram (
        .clk   (clk),
        .we    (ram_we),
        .waddr (ram_waddr),
        .wdata (ram_wdata),
        .raddr (ram_raddr),
        .rdata (ram_rdata)
    );

    assign out_valid    = out_valid_reg;
    assign status       = out_reg.status;
    assign top_key      = out_reg.top_key;
    assign entry_count  = out_reg.count;
    assign order_is_min = out_reg.order_is_min;

endmodule
